// ===== rtl/core/rwdm_pkg.sv =====
// ----------------------------------------------------------------------------
// rwdm_pkg
// Shared types and constants of the robust window depth median core.
// ----------------------------------------------------------------------------
package rwdm_pkg;

    localparam int NUM_TAPS   = 9;
    localparam int SAMPLE_W   = 16;
    localparam int MASK_W     = 9;
    localparam int COUNT_W    = 4;
    localparam int MIN_COUNT  = 3;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    // Register index, taken from paddr[3:2]
    localparam logic [REG_IDX_W-1:0] REG_MIN_RAW        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_RAW        = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX_SPREAD_RAW = 2'd2;

    localparam logic [SAMPLE_W-1:0] MIN_RAW_RST        = 16'd1;
    localparam logic [SAMPLE_W-1:0] MAX_RAW_RST        = 16'hFFFF;
    localparam logic [SAMPLE_W-1:0] MAX_SPREAD_RAW_RST = 16'd200;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
        logic [SAMPLE_W-1:0] sample_8;
        logic [MASK_W-1:0]   in_bounds_mask;
    } in_t;

    typedef struct packed {
        logic                depth_valid;
        logic [SAMPLE_W-1:0] depth_raw;
        logic [COUNT_W-1:0]  sample_count;
    } out_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] min_raw;
        logic [SAMPLE_W-1:0] max_raw;
        logic [SAMPLE_W-1:0] max_spread_raw;
    } cfg_t;

endpackage

// ===== rtl/core/rwdm_rank_select.sv =====
// ----------------------------------------------------------------------------
// rwdm_rank_select
// Masked 3x3 median by pairwise ranking, with count and spread checks.
// ----------------------------------------------------------------------------
module rwdm_rank_select (
    input  rwdm_pkg::in_t  item,
    input  rwdm_pkg::cfg_t cfg,
    output rwdm_pkg::out_t result
);
    import rwdm_pkg::*;

    logic [NUM_TAPS-1:0][SAMPLE_W-1:0] smp;
    logic [NUM_TAPS-1:0]               use_tap;
    // ahead[i][j]: tap j sorts before tap i (ties broken by window position)
    logic [NUM_TAPS-1:0][NUM_TAPS-1:0] ahead;
    logic [NUM_TAPS-1:0][COUNT_W-1:0]  rank;
    logic [COUNT_W-1:0]                count;
    logic [COUNT_W-1:0]                target;
    logic [COUNT_W-1:0]                last;
    logic [SAMPLE_W-1:0]               pick;
    logic [SAMPLE_W-1:0]               lo;
    logic [SAMPLE_W-1:0]               hi;
    logic                              enough;
    logic                              spread_ok;
    logic                              valid;

    assign smp = {item.sample_8, item.sample_7, item.sample_6,
                  item.sample_5, item.sample_4, item.sample_3,
                  item.sample_2, item.sample_1, item.sample_0};

    always_comb begin
        for (int k = 0; k < NUM_TAPS; k++) begin
            use_tap[k] = item.in_bounds_mask[k] && (smp[k] != '0) &&
                         (smp[k] >= cfg.min_raw) && (smp[k] <= cfg.max_raw);
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TAPS; i++) begin
            for (int j = 0; j < NUM_TAPS; j++) begin
                if (j < i) begin
                    ahead[i][j] = (smp[j] <= smp[i]);
                end else if (j > i) begin
                    ahead[i][j] = (smp[j] < smp[i]);
                end else begin
                    ahead[i][j] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TAPS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < NUM_TAPS; j++) begin
                rank[i] = rank[i] + COUNT_W'(use_tap[j] & ahead[i][j]);
            end
        end
    end

    always_comb begin
        count = '0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            count = count + COUNT_W'(use_tap[k]);
        end
    end

    assign target = count >> 1;
    assign last   = count - COUNT_W'(1);

    // Ranks of counted taps are unique, so each select is one-hot
    always_comb begin
        pick = '0;
        lo   = '0;
        hi   = '0;
        for (int i = 0; i < NUM_TAPS; i++) begin
            pick = pick | ({SAMPLE_W{use_tap[i] && (rank[i] == target)}} & smp[i]);
            lo   = lo   | ({SAMPLE_W{use_tap[i] && (rank[i] == '0)}}    & smp[i]);
            hi   = hi   | ({SAMPLE_W{use_tap[i] && (rank[i] == last)}}  & smp[i]);
        end
    end

    assign enough    = (count >= COUNT_W'(MIN_COUNT));
    assign spread_ok = ({1'b0, hi} <= ({1'b0, lo} + {1'b0, cfg.max_spread_raw}));
    assign valid     = enough && spread_ok;

    assign result.depth_valid  = valid;
    assign result.depth_raw    = valid ? pick : '0;
    assign result.sample_count = count;

endmodule

// ===== rtl/core/robust_window_depth_median_core.sv =====
// ----------------------------------------------------------------------------
// robust_window_depth_median_core
// Masked 3x3 depth median with range, count and spread checks.
// ----------------------------------------------------------------------------
// Takes one 3x3 window of raw depth per transaction and returns one result
// transaction for it. Throughput is one window per clock while m_ready is high.
// The window is held in the input register, the ranking network works on it,
// and its result is held in the result register, which drives m_valid. The
// ranking network is single-pass: pairwise sample compares over the 36 tap
// pairs, per-tap rank counts, one-hot selection of median, min and max, and
// one spread compare. Backpressure on m_ready stalls the result register
// and then the input register; with both holding a transaction s_ready
// drops. Limits are set through the APB port: min_raw at 0x0, max_raw at
// 0x4, max_spread_raw at 0x8; write them only while no transaction is in
// flight.
module robust_window_depth_median_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rwdm_pkg::in_t                       s_item,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output rwdm_pkg::out_t                      m_result,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rwdm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rwdm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rwdm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import rwdm_pkg::*;

    localparam int PAD_W = APB_DATA_W - SAMPLE_W;

    // configuration registers
    cfg_t                 cfg_reg;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    // pipeline
    logic  in_valid_reg;
    in_t   in_item_reg;
    logic  out_valid_reg;
    out_t  out_result_reg;
    out_t  result_next;
    logic  out_free;
    logic  advance;

    // ------------------------------------------------------------------
    // APB: zero wait state, register picked by word address
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_raw        <= MIN_RAW_RST;
            cfg_reg.max_raw        <= MAX_RAW_RST;
            cfg_reg.max_spread_raw <= MAX_SPREAD_RAW_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_RAW:        cfg_reg.min_raw        <= pwdata[SAMPLE_W-1:0];
                REG_MAX_RAW:        cfg_reg.max_raw        <= pwdata[SAMPLE_W-1:0];
                REG_MAX_SPREAD_RAW: cfg_reg.max_spread_raw <= pwdata[SAMPLE_W-1:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_RAW:        prdata = {PAD_W'(0), cfg_reg.min_raw};
            REG_MAX_RAW:        prdata = {PAD_W'(0), cfg_reg.max_raw};
            REG_MAX_SPREAD_RAW: prdata = {PAD_W'(0), cfg_reg.max_spread_raw};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Two-stage pipeline. The result register frees up when empty or when
    // its transaction is taken; the input register moves forward whenever
    // the result register is free, so a window can enter every cycle.
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
    end

    rwdm_rank_select u_rank_select (
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

`ifndef SYNTHESIS
    // a valid depth needs at least three counted samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result.depth_valid)
            |-> (m_result.sample_count >= COUNT_W'(MIN_COUNT)))
        else $error("valid depth with too few counted samples");

    // an invalid result carries zero depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_result.depth_valid) |-> (m_result.depth_raw == '0))
        else $error("invalid result with nonzero depth");

    // never more counted samples than window taps
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_result.sample_count <= COUNT_W'(NUM_TAPS)))
        else $error("sample count exceeds window size");

    // a held window moves into a free result register on the next edge
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free) |=> out_valid_reg)
        else $error("window lost between input and result register");

    // reset empties both stages
    assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg))
        else $error("pipeline not empty after reset");
`endif

endmodule

// ===== test/window_median_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_median_checker
// Watches the window and result channels of the depth median core, predicts
// each result from the accepted window and the limits seen on the register
// port, and compares results in order.
// ----------------------------------------------------------------------------
module window_median_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  rwdm_pkg::in_t                   s_item,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  rwdm_pkg::out_t                  m_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [rwdm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rwdm_pkg::APB_DATA_W-1:0] pwdata,
    output int                              mismatches,
    output int                              pending
);
    import rwdm_pkg::*;

    logic [SAMPLE_W-1:0] min_raw_q;
    logic [SAMPLE_W-1:0] max_raw_q;
    logic [SAMPLE_W-1:0] spread_q;
    out_t                expected_depths[$];

    // Keep the counted samples, sort them, take the one at count/2.
    function automatic out_t median_depth_of(input in_t w,
                                             input logic [SAMPLE_W-1:0] lo_lim,
                                             input logic [SAMPLE_W-1:0] hi_lim,
                                             input logic [SAMPLE_W-1:0] spread_lim);
        logic [SAMPLE_W-1:0] tap [NUM_TAPS];
        logic [SAMPLE_W-1:0] kept [NUM_TAPS];
        logic [SAMPLE_W-1:0] t;
        int                  n;
        int                  i;
        int                  j;
        out_t                r;
        tap = '{w.sample_0, w.sample_1, w.sample_2, w.sample_3, w.sample_4,
                w.sample_5, w.sample_6, w.sample_7, w.sample_8};
        n = 0;
        for (i = 0; i < NUM_TAPS; i++) begin
            if (w.in_bounds_mask[i] && tap[i] != '0 && tap[i] >= lo_lim &&
                tap[i] <= hi_lim) begin
                kept[n] = tap[i];
                n++;
            end
        end
        for (i = 1; i < n; i++) begin
            t = kept[i];
            j = i;
            while (j > 0 && kept[j-1] > t) begin
                kept[j] = kept[j-1];
                j--;
            end
            kept[j] = t;
        end
        r = '0;
        r.sample_count = COUNT_W'(n);
        if (n >= MIN_COUNT && (kept[n-1] - kept[0]) <= spread_lim) begin
            r.depth_valid = 1'b1;
            r.depth_raw   = kept[n/2];
        end
        return r;
    endfunction

    function automatic void report(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    always @(posedge aclk) begin : monitor
        out_t want;
        if (!aresetn) begin
            min_raw_q = MIN_RAW_RST;
            max_raw_q = MAX_RAW_RST;
            spread_q  = MAX_SPREAD_RAW_RST;
            expected_depths.delete();
            mismatches = 0;
            pending <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_MIN_RAW:        min_raw_q = pwdata[SAMPLE_W-1:0];
                    REG_MAX_RAW:        max_raw_q = pwdata[SAMPLE_W-1:0];
                    REG_MAX_SPREAD_RAW: spread_q  = pwdata[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
            // retire before taking the new window, so a spurious result
            // can never pair with a window accepted on the same edge
            if (m_valid && m_ready) begin
                if (expected_depths.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, m_result);
                end else begin
                    want = expected_depths.pop_front();
                    if (m_result.depth_valid !== want.depth_valid) begin
                        mismatches++;
                        report("depth_valid", want.depth_valid, m_result.depth_valid);
                    end
                    if (m_result.depth_raw !== want.depth_raw) begin
                        mismatches++;
                        report("depth_raw", want.depth_raw, m_result.depth_raw);
                    end
                    if (m_result.sample_count !== want.sample_count) begin
                        mismatches++;
                        report("sample_count", want.sample_count, m_result.sample_count);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_depths.insert(expected_depths.size(),
                                       median_depth_of(s_item, min_raw_q, max_raw_q,
                                                       spread_q));
            end
            pending <= expected_depths.size();
        end
    end

endmodule

// ===== test/robust_window_depth_median_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// robust_window_depth_median_core_test
// Directed and random windows through the masked depth median core.
// ----------------------------------------------------------------------------
// A short directed set covers empty and full masks, zero samples, the count
// threshold, the spread limit, even counts and ties. Random windows follow,
// mostly clustered around a base depth so the spread check both passes and
// fails, under several limit settings including inverted and single-value
// ranges. Both channel sides stall in random bursts; one long result-side
// hold-off fills the core. The checker beside the core predicts and compares.
// ----------------------------------------------------------------------------
module robust_window_depth_median_core_test;
    import rwdm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transaction
    localparam int HOLD_CYCLES    = 80;    // long result-side hold-off
    localparam int HOLD_AFTER     = 300;   // windows sent before the hold-off
    localparam int DRAIN_CYCLES   = 8;     // extra wait after the checker has nothing pending

    typedef enum logic [1:0] {WIN_CLUSTER, WIN_TIES, WIN_NOISE} win_kind_e;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_item  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    mismatches;
    int                    pending;

    // stimulus-side copy of the limits, used only to shape random windows
    int                    lim_lo     = MIN_RAW_RST;
    int                    lim_hi     = MAX_RAW_RST;
    int                    lim_spread = MAX_SPREAD_RAW_RST;

    int                    sent_count  = 0;
    logic                  calm        = 1'b0;  // last part: no idling at all
    logic                  held        = 1'b0;
    logic [15:0]           cycle_count = '0;

    robust_window_depth_median_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    window_median_checker median_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Idle bursts only fire while cycle_count[7:6] is nonzero, in three of every
    // four stretches, so there are runs of back-to-back traffic in between.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 16'd1;
    end

    function automatic in_t win_of(input logic [SAMPLE_W-1:0] v [NUM_TAPS],
                                   input logic [MASK_W-1:0] m);
        in_t w;
        w.sample_0       = v[0];
        w.sample_1       = v[1];
        w.sample_2       = v[2];
        w.sample_3       = v[3];
        w.sample_4       = v[4];
        w.sample_5       = v[5];
        w.sample_6       = v[6];
        w.sample_7       = v[7];
        w.sample_8       = v[8];
        w.in_bounds_mask = m;
        return w;
    endfunction

    // Clustered windows sit on a base inside the current range with jitter
    // around the spread limit; ties draw from two close values. Both get a
    // few zeros and outliers. Noise windows are fully random.
    function automatic in_t random_window();
        logic [SAMPLE_W-1:0] v [NUM_TAPS];
        logic [MASK_W-1:0]   m;
        int                  base;
        int                  reach;
        int                  alt;
        int                  pick;
        int                  t;
        int                  k;
        win_kind_e           kind;
        pick = $urandom_range(0, 9);
        kind = (pick < 7) ? WIN_CLUSTER : (pick < 9) ? WIN_TIES : WIN_NOISE;
        base = (lim_lo <= lim_hi) ? $urandom_range(lim_lo, lim_hi) : $urandom_range(0, 65535);
        reach = $urandom_range(0, 1) ? lim_spread : lim_spread + lim_spread / 4 + 4;
        reach = $urandom_range(0, reach);
        alt   = base + $urandom_range(0, reach);
        for (k = 0; k < NUM_TAPS; k++) begin
            case (kind)
                WIN_CLUSTER: t = base + $urandom_range(0, reach);
                WIN_TIES:    t = $urandom_range(0, 1) ? base : alt;
                default:     t = $urandom_range(0, 65535);
            endcase
            if (kind != WIN_NOISE) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    t = 0;
                end else if (pick < 10) begin
                    t = $urandom_range(0, 65535);
                end
                m[k] = ($urandom_range(0, 99) < 85);
            end else begin
                m[k] = 1'($urandom_range(0, 1));
            end
            v[k] = (t > 65535) ? 16'hFFFF : t[SAMPLE_W-1:0];
        end
        return win_of(v, m);
    endfunction

    // One window transaction; may idle a burst first. Returns on the edge
    // that accepts it, leaving s_valid high for the caller to reuse.
    task automatic send_window(input in_t w);
        if (!calm && cycle_count[7:6] != 2'b00 && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= w;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_window(random_window());
    endtask

    // setup cycle, then access cycle; the write lands when pready is high
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                             input logic [SAMPLE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain the core completely before touching the limits.
    task automatic set_limits(input int lo, input int hi, input int spread);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_MIN_RAW, lo[SAMPLE_W-1:0]);
        write_reg(REG_MAX_RAW, hi[SAMPLE_W-1:0]);
        write_reg(REG_MAX_SPREAD_RAW, spread[SAMPLE_W-1:0]);
        lim_lo     = lo;
        lim_hi     = hi;
        lim_spread = spread;
    endtask

    // Result side: random stall bursts, plus one long hold-off while the
    // window side keeps offering, so the core fills and drops s_ready.
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (!held && sent_count >= HOLD_AFTER) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (!calm && cycle_count[7:6] != 2'b00 &&
                         $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed windows under the reset limits (1..65535, spread 200).
        // nothing counted: zeros, then an empty mask
        send_window(win_of('{default: 16'd0}, 9'h1FF));
        send_window(win_of('{default: 16'd500}, 9'h000));
        // full window at the top value
        send_window(win_of('{default: 16'hFFFF}, 9'h1FF));
        // exactly three counted, then only two
        send_window(win_of('{16'd100, 16'd150, 16'd120, 16'd9, 16'd9, 16'd9,
                             16'd9, 16'd9, 16'd9}, 9'h007));
        send_window(win_of('{16'd100, 16'd150, 16'd120, 16'd9, 16'd9, 16'd9,
                             16'd9, 16'd9, 16'd9}, 9'h003));
        // spread right at the limit, then one over
        send_window(win_of('{16'd1000, 16'd1200, 16'd1100, 16'd0, 16'd0, 16'd0,
                             16'd0, 16'd0, 16'd0}, 9'h007));
        send_window(win_of('{16'd1000, 16'd1201, 16'd1100, 16'd0, 16'd0, 16'd0,
                             16'd0, 16'd0, 16'd0}, 9'h007));
        // even count picks the upper median
        send_window(win_of('{16'd40, 16'd10, 16'd30, 16'd20, 16'd0, 16'd0,
                             16'd0, 16'd0, 16'd0}, 9'h00F));
        // all tied
        send_window(win_of('{default: 16'd500}, 9'h1FF));
        // zeros in bounds are skipped
        send_window(win_of('{16'd0, 16'd300, 16'd0, 16'd310, 16'd0, 16'd320,
                             16'd0, 16'd330, 16'd305}, 9'h1FF));
        // range edges together: count of nine, spread far too large
        send_window(win_of('{16'd1, 16'hFFFF, 16'd1, 16'd2, 16'd3, 16'd4,
                             16'd5, 16'd6, 16'd7}, 9'h1FF));
        send_window(win_of('{16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6,
                             16'd7, 16'd8, 16'd9}, 9'h1FF));
        // alternating bit patterns
        send_window(win_of('{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                             16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA}, 9'h155));
        send_window(win_of('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                             16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}, 9'h0AA));
        send_random(200);

        // widest limits; a zero is still not counted with min_raw at 0
        set_limits(0, 65535, 65535);
        send_window(win_of('{16'd0, 16'd0, 16'd0, 16'd700, 16'd710, 16'd720,
                             16'd0, 16'd0, 16'd0}, 9'h1FF));
        send_random(250);

        // narrow band with range edges just in and just out
        set_limits(500, 4000, 100);
        send_window(win_of('{16'd499, 16'd500, 16'd550, 16'd4000, 16'd4001,
                             16'd600, 16'd0, 16'd520, 16'd510}, 9'h1FF));
        send_window(win_of('{16'd499, 16'd500, 16'd501, 16'd4001, 16'd520,
                             16'd540, 16'd560, 16'd580, 16'd600}, 9'h1FF));
        send_random(250);

        // inverted limits: nothing can count
        set_limits(65535, 0, 0);
        send_window(win_of('{default: 16'd1000}, 9'h1FF));
        send_random(60);

        // single-value range with zero spread allowed
        set_limits(65535, 65535, 0);
        send_window(win_of('{default: 16'hFFFF}, 9'h1FF));
        send_window(win_of('{16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'd1,
                             16'hFFFE, 16'hFFFF, 16'd0, 16'hFFFF}, 9'h1FF));
        send_random(80);

        // a few random settings
        repeat (3) begin
            set_limits($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 2000));
            send_random(100);
        end

        // back to the reset values, no idling on either side
        set_limits(MIN_RAW_RST, MAX_RAW_RST, MAX_SPREAD_RAW_RST);
        calm = 1'b1;
        send_random(200);

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
